// ===== rtl/core/clcd4_pkg.sv =====
// Shared types, opcodes and constants of the character-LCD expander sequencer.
package clcd4_pkg;

  // Operation codes of the input beat.
  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_CMD    = 2'd1,
    OP_DATA   = 2'd2,
    OP_SETPOS = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ENABLE_MASK    = 2'd0,
    CFG_BACKLIGHT_MASK = 2'd1,
    CFG_ROW2_OFFSET    = 2'd2,
    CFG_ROW3_OFFSET    = 2'd3
  } cfg_idx_t;

  localparam logic [6:0] ROW1_START = 7'h40;
  localparam logic [7:0] ADDR_CMD   = 8'h80;
  localparam logic [7:0] CTRL_LIMIT = 8'h1f;

  // Nibble counts: init runs 4 wake-up nibbles and 7 command bytes.
  localparam logic [4:0] INIT_LAST_NIB = 5'd17;
  localparam logic [4:0] BYTE_LAST_NIB = 5'd1;
  localparam logic [1:0] PHASE_LAST    = 2'd2;

  // One unit of work for the back end: a byte to send, or the init run.
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] value;
  } job_t;

  typedef struct packed {
    logic [7:0] enable_mask;
    logic [7:0] backlight_mask;
  } masks_t;

  typedef struct packed {
    logic [6:0] row2_offset;
    logic [6:0] row3_offset;
  } row_offs_t;

  // Nibble stream of the init run.
  function automatic logic [3:0] init_nibble(input logic [4:0] idx);
    logic [3:0] nib;
    unique case (idx)
      5'd0, 5'd1, 5'd2: nib = 4'h3;
      5'd3:             nib = 4'h2;
      5'd4:             nib = 4'h2;
      5'd5:             nib = 4'h8;
      5'd6:             nib = 4'h0;
      5'd7:             nib = 4'h1;
      5'd8:             nib = 4'h0;
      5'd9:             nib = 4'h2;
      5'd10:            nib = 4'h1;
      5'd11:            nib = 4'h0;
      5'd12:            nib = 4'h0;
      5'd13:            nib = 4'hc;
      5'd14:            nib = 4'h0;
      5'd15:            nib = 4'h6;
      5'd16:            nib = 4'h0;
      5'd17:            nib = 4'h2;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

// ===== rtl/core/clcd4_front.sv =====
// Front end: accept input beats, classify them and register a job for the queue.
module clcd4_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [7:0]           value,
  input  logic [1:0]           row,
  input  logic [5:0]           column,
  input  clcd4_pkg::row_offs_t offs,
  output logic                 job_valid,
  input  logic                 job_ready,
  output clcd4_pkg::job_t      job
);

  logic            keep;
  logic [6:0]      row_start;
  logic [7:0]      pos_addr;
  clcd4_pkg::job_t job_next;

  always_comb begin
    unique case (row)
      2'd0:    row_start = 7'd0;
      2'd1:    row_start = clcd4_pkg::ROW1_START;
      2'd2:    row_start = offs.row2_offset;
      default: row_start = offs.row3_offset;
    endcase
  end

  assign pos_addr = clcd4_pkg::ADDR_CMD + {1'b0, row_start} + {2'b00, column};

  always_comb begin
    keep     = 1'b1;
    job_next = '0;
    unique case (clcd4_pkg::op_t'(opcode))
      clcd4_pkg::OP_INIT: begin
        job_next.is_init = 1'b1;
      end
      clcd4_pkg::OP_CMD: begin
        job_next.value = value;
      end
      clcd4_pkg::OP_DATA: begin
        job_next.rs    = 1'b1;
        job_next.value = value;
        // drop control characters
        keep           = (value > clcd4_pkg::CTRL_LIMIT);
      end
      clcd4_pkg::OP_SETPOS: begin
        job_next.value = pos_addr;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      job_valid <= keep;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job <= job_next;
    end
  end

endmodule

// ===== rtl/core/clcd4_queue.sv =====
// Short job queue between the front end and the back end.
module clcd4_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            push_ready,
  input  clcd4_pkg::job_t push_job,
  output logic            pop_valid,
  input  logic            pop,
  output clcd4_pkg::job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clcd4_pkg::job_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/core/clcd4_back.sv =====
// Back end: expand each job into expander bytes, three per nibble, into an output register.
module clcd4_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_pop,
  input  clcd4_pkg::job_t   job_in,
  input  clcd4_pkg::masks_t masks,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t          state;
  clcd4_pkg::job_t job;
  logic [4:0]      nib_idx;
  logic [1:0]      phase;
  logic [3:0]      nib;
  logic [4:0]      last_nib;
  logic            at_end;
  logic            out_free;
  logic            emit;
  logic [7:0]      strobe_hi;
  logic [7:0]      strobe_lo;
  logic [7:0]      beat;

  always_comb begin
    if (job.is_init) begin
      nib = clcd4_pkg::init_nibble(nib_idx);
    end else if (nib_idx == 5'd0) begin
      nib = job.value[7:4];
    end else begin
      nib = job.value[3:0];
    end
  end

  assign last_nib  = job.is_init ? clcd4_pkg::INIT_LAST_NIB : clcd4_pkg::BYTE_LAST_NIB;
  assign at_end    = (nib_idx == last_nib) && (phase == clcd4_pkg::PHASE_LAST);
  assign strobe_hi = masks.backlight_mask | {nib, 4'h0} | masks.enable_mask | {7'd0, job.rs};
  assign strobe_lo = strobe_hi & ~masks.enable_mask;

  always_comb begin
    unique case (phase)
      2'd0:    beat = strobe_hi;
      2'd1:    beat = strobe_lo;
      default: beat = strobe_lo | masks.enable_mask;
    endcase
  end

  assign out_free = !out_valid || out_ready;
  assign emit     = (state == ST_RUN) && out_free;
  assign job_pop  = job_valid && ((state == ST_IDLE) || (emit && at_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      nib_idx   <= '0;
      phase     <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (job_pop) begin
        state   <= ST_RUN;
        nib_idx <= '0;
        phase   <= '0;
      end else if (emit) begin
        if (at_end) begin
          state <= ST_IDLE;
        end
        if (phase == clcd4_pkg::PHASE_LAST) begin
          phase   <= '0;
          nib_idx <= nib_idx + 1'b1;
        end else begin
          phase <= phase + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_in;
    end
    if (emit) begin
      out_byte <= beat;
      out_last <= at_end;
    end
  end

endmodule

// ===== rtl/core/char_lcd_4bit_expander_sequencer.sv =====
// Top level of the character-LCD sequencer for a 4-bit I2C port expander.
//
// Input channel (s_*): one beat is one LCD operation (init, command byte,
// data character, set position). The front end classifies it, drops data
// characters of 0x1f or below, and registers a job into a short queue.
// Output channel (m_*): one beat is one byte for the port expander; tlast
// marks the final byte of an operation. Each nibble goes out as three
// bytes (enable high, enable low, enable high), upper nibble first.
// Throughput: a command, character or set position expands to 6 bytes and
// init to 54; the back end's sequencer sends one byte per cycle while the
// receiver takes them, and a job already waiting in the queue follows
// without a gap. An input beat passes the front-end job register, the queue
// write, the sequencer load and the output register on its way out.
// A stalled receiver holds the output register; the sequencer waits, the queue
// and the front-end job register fill, and only then does s_tready drop.
// Reset clears the queue, the sequencer and the output valid, and loads
// the registers with enable mask 0x04, backlight mask 0x08, row 2 offset
// 20 and row 3 offset 84. Write registers through cfg_* only while idle.
module char_lcd_4bit_expander_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // opcode[1:0], value[9:2], row[11:10], column[17:12], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // expander_byte[7:0]
  output logic        m_tlast,   // last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  clcd4_pkg::masks_t    masks;
  clcd4_pkg::row_offs_t offs;
  clcd4_pkg::job_t      fe_job;
  clcd4_pkg::job_t      q_job;
  logic                 fe_valid;
  logic                 q_ready;
  logic                 q_valid;
  logic                 q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      masks.enable_mask    <= 8'h04;
      masks.backlight_mask <= 8'h08;
      offs.row2_offset     <= 7'd20;
      offs.row3_offset     <= 7'd84;
    end else if (cfg_we) begin
      unique case (clcd4_pkg::cfg_idx_t'(cfg_index))
        clcd4_pkg::CFG_ENABLE_MASK:    masks.enable_mask    <= cfg_data;
        clcd4_pkg::CFG_BACKLIGHT_MASK: masks.backlight_mask <= cfg_data;
        clcd4_pkg::CFG_ROW2_OFFSET:    offs.row2_offset     <= cfg_data[6:0];
        clcd4_pkg::CFG_ROW3_OFFSET:    offs.row3_offset     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Classify the operation and build the byte to send.
  clcd4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .opcode    (s_tdata[1:0]),
    .value     (s_tdata[9:2]),
    .row       (s_tdata[11:10]),
    .column    (s_tdata[17:12]),
    .offs      (offs),
    .job_valid (fe_valid),
    .job_ready (q_ready),
    .job       (fe_job)
  );

  // Decouple the front end from the byte sequencer.
  clcd4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fe_valid),
    .push_ready (q_ready),
    .push_job   (fe_job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_job    (q_job)
  );

  // Expand jobs into expander bytes.
  clcd4_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .job_in    (q_job),
    .masks     (masks),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

  // The sequencer only takes a job the queue actually holds.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("job taken from an empty queue");

  // After reset the output is empty and the input side is open.
  a_reset_clean: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  // A full queue always has a job to offer.
  a_full_valid: assert property (@(posedge clk) disable iff (rst) !q_ready |-> q_valid)
    else $error("queue reports full and empty at once");

endmodule
